// ===== rtl/cdq_pkg.sv =====
// Package for the circular list deque engine: sizes, codes, item and cell types.
// Used by cdq_cell and circular_list_deque_engine_unit; depends on nothing else.
package cdq_pkg;

    localparam int POOL_NODES       = 64;
    localparam int VALUE_BITS       = 32;
    localparam int COUNT_BITS       = $clog2(POOL_NODES + 1);
    localparam int ENTRY_COUNT_BITS = 7;

    typedef logic [VALUE_BITS-1:0] t_value;
    typedef logic [COUNT_BITS-1:0] t_count;

    typedef enum logic [2:0] {
        K_INS_FRONT = 3'd0,
        K_INS_BACK  = 3'd1,
        K_DEL_FRONT = 3'd2,
        K_DEL_BACK  = 3'd3,
        K_DEL_VALUE = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEED,
        S_SCAN
    } t_state;

    // Command broadcast to every cell of the chain.
    typedef enum logic [2:0] {
        C_IDLE,
        C_INS_FRONT,
        C_INS_BACK,
        C_DEL_FRONT,
        C_DEL_BACK,
        C_SCAN,
        C_REMOVE,
        C_ABORT
    } t_cmd;

    typedef struct packed {
        logic [2:0]         kind;
        logic signed [31:0] item_value;
    } t_in_item;

    typedef struct packed {
        t_status                     status;
        logic [ENTRY_COUNT_BITS-1:0] entry_count;
    } t_out_item;

    typedef struct packed {
        logic   valid;
        t_value value;
    } t_cell;

    // What a cell reports about the search token it holds.
    typedef struct packed {
        logic hit;
        logic hole;
        logic miss;
    } t_probe;

endpackage

// ===== rtl/cdq_cell.sv =====
// One node slot of the deque chain: value, occupancy and search token.
// Depends on cdq_pkg; instantiated in a row by circular_list_deque_engine_unit.
module cdq_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  cdq_pkg::t_cmd   i_cmd,
    input  cdq_pkg::t_value i_key,
    input  cdq_pkg::t_cell  i_left,
    input  cdq_pkg::t_cell  i_right,
    input  logic            i_tok_in,
    output cdq_pkg::t_cell  o_cell,
    output logic            o_tok,
    output cdq_pkg::t_probe o_probe
);

    logic            r_valid;
    cdq_pkg::t_value r_value;
    logic            r_tok;
    logic            r_behind;
    logic            w_match;

    assign w_match = (r_value == i_key);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_tok    <= 1'b0;
            r_behind <= 1'b0;
        end else begin
            case (i_cmd)
                cdq_pkg::C_INS_FRONT: begin
                    r_valid <= i_left.valid;
                end
                cdq_pkg::C_INS_BACK: begin
                    if (!r_valid && i_left.valid) begin
                        r_valid <= 1'b1;
                    end
                end
                cdq_pkg::C_DEL_FRONT: begin
                    r_valid <= i_right.valid;
                end
                cdq_pkg::C_DEL_BACK: begin
                    if (r_valid && !i_right.valid) begin
                        r_valid <= 1'b0;
                    end
                end
                cdq_pkg::C_SCAN: begin
                    r_tok    <= i_tok_in;
                    r_behind <= r_behind | r_tok;
                end
                cdq_pkg::C_REMOVE: begin
                    if (!r_behind) begin
                        r_valid <= i_right.valid;
                    end
                    r_tok    <= 1'b0;
                    r_behind <= 1'b0;
                end
                cdq_pkg::C_ABORT: begin
                    r_tok    <= 1'b0;
                    r_behind <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd)
            cdq_pkg::C_INS_FRONT: begin
                r_value <= i_left.value;
            end
            cdq_pkg::C_INS_BACK: begin
                if (!r_valid && i_left.valid) begin
                    r_value <= i_key;
                end
            end
            cdq_pkg::C_DEL_FRONT: begin
                r_value <= i_right.value;
            end
            cdq_pkg::C_REMOVE: begin
                if (!r_behind) begin
                    r_value <= i_right.value;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_cell.valid  = r_valid;
    assign o_cell.value  = r_value;
    assign o_tok         = r_tok;
    assign o_probe.hit   = r_tok && r_valid && w_match;
    assign o_probe.hole  = r_tok && !r_valid;
    assign o_probe.miss  = r_tok && r_valid && !w_match;

endmodule

// ===== rtl/circular_list_deque_engine_unit.sv =====
// Top level of the circular list deque engine: control sequencer and the cell chain.
// Depends on cdq_pkg and cdq_cell.
//
// The list lives in a row of POOL_NODES cells kept packed from the front: cell 0
// holds the front node, the last occupied cell holds the tail. Every item gives
// exactly one result with a status (ok, empty, not found, full) and the node count
// after the operation. Insert front, insert back, delete front and delete back
// finish in the cycle the item is taken (one item per cycle while results drain):
// the chain shifts right or left by one cell, or the cell at the occupancy edge
// fills or clears. Delete value sends a search token from the front down the chain,
// one cell per cycle, until it meets the first matching node, an empty cell or the
// last cell. On a match the cells from the matching node onward take their right
// neighbor in one step, which closes the gap. An insert into a full pool is
// refused with the full status; a delete on an empty list only reports empty;
// unknown kinds leave the list alone and report ok. Results pass through a
// one-item output register.
module circular_list_deque_engine_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  cdq_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output cdq_pkg::t_out_item o_out_item
);

    cdq_pkg::t_state    r_state;
    cdq_pkg::t_state    n_state;
    cdq_pkg::t_count    r_count;
    cdq_pkg::t_count    n_count;
    cdq_pkg::t_value    r_key;
    cdq_pkg::t_value    n_key;
    logic               r_out_valid;
    cdq_pkg::t_out_item r_out_item;

    cdq_pkg::t_cmd      w_cmd;
    cdq_pkg::t_status   w_status;
    cdq_pkg::t_value    w_key;
    cdq_pkg::t_value    w_in_value;
    logic               w_load;
    logic               w_seed;
    logic               w_in_acc;
    logic               w_out_free;
    logic               w_full;
    logic               w_empty;
    logic               w_hit;
    logic               w_miss;

    cdq_pkg::t_cell     w_cell  [cdq_pkg::POOL_NODES];
    cdq_pkg::t_probe    w_probe [cdq_pkg::POOL_NODES];
    logic [cdq_pkg::POOL_NODES-1:0] w_tok_map;
    logic [cdq_pkg::POOL_NODES-1:0] w_valid_map;
    logic [cdq_pkg::POOL_NODES-1:0] w_hit_map;
    logic [cdq_pkg::POOL_NODES-1:0] w_hole_map;

    // Handshake: take an item only when idle and the result slot can drain.
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != cdq_pkg::S_IDLE) || !w_out_free;
    assign w_in_acc   = i_in_valid && !o_in_stall;

    assign w_full     = (r_count == cdq_pkg::COUNT_BITS'(cdq_pkg::POOL_NODES));
    assign w_empty    = (r_count == '0);
    assign w_in_value = cdq_pkg::VALUE_BITS'(i_in_item.item_value);

    // Broadcast the incoming value while idle, the held search key otherwise.
    assign w_key = (r_state == cdq_pkg::S_IDLE) ? w_in_value : r_key;

    // Cell chain: left neighbor of cell 0 is the new front node, right of the last
    // cell is an empty slot.
    genvar gi;
    generate
        for (gi = 0; gi < cdq_pkg::POOL_NODES; gi++) begin : g_cell
            cdq_pkg::t_cell w_left;
            cdq_pkg::t_cell w_right;
            logic           w_tok_in;

            if (gi == 0) begin : g_head
                assign w_left.valid = 1'b1;
                assign w_left.value = w_key;
                assign w_tok_in     = w_seed;
            end else begin : g_body
                assign w_left   = w_cell[gi-1];
                assign w_tok_in = w_tok_map[gi-1];
            end

            if (gi == cdq_pkg::POOL_NODES - 1) begin : g_end
                assign w_right.valid = 1'b0;
                assign w_right.value = '0;
            end else begin : g_mid
                assign w_right = w_cell[gi+1];
            end

            cdq_cell u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_cmd    (w_cmd),
                .i_key    (w_key),
                .i_left   (w_left),
                .i_right  (w_right),
                .i_tok_in (w_tok_in),
                .o_cell   (w_cell[gi]),
                .o_tok    (w_tok_map[gi]),
                .o_probe  (w_probe[gi])
            );

            assign w_valid_map[gi] = w_cell[gi].valid;
            assign w_hit_map[gi]   = w_probe[gi].hit;
            assign w_hole_map[gi]  = w_probe[gi].hole;
        end
    endgenerate

    // Search ends on a match, on reaching the first empty cell, or when the
    // token sits on the last cell without a match.
    assign w_hit  = |w_hit_map;
    assign w_miss = (|w_hole_map) || w_probe[cdq_pkg::POOL_NODES-1].miss;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            cdq_pkg::S_IDLE: begin
                if (w_in_acc && (cdq_pkg::t_kind'(i_in_item.kind) == cdq_pkg::K_DEL_VALUE)
                        && !w_empty) begin
                    n_state = cdq_pkg::S_SEED;
                end
            end
            cdq_pkg::S_SEED: begin
                n_state = cdq_pkg::S_SCAN;
            end
            cdq_pkg::S_SCAN: begin
                if ((w_hit || w_miss) && w_out_free) begin
                    n_state = cdq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = cdq_pkg::S_IDLE;
            end
        endcase
    end

    // Commands to the chain, count update and result load.
    always_comb begin
        w_cmd    = cdq_pkg::C_IDLE;
        w_seed   = 1'b0;
        w_load   = 1'b0;
        w_status = cdq_pkg::ST_OK;
        n_count  = r_count;
        n_key    = r_key;
        case (r_state)
            cdq_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    w_load = 1'b1;
                    case (cdq_pkg::t_kind'(i_in_item.kind))
                        cdq_pkg::K_INS_FRONT: begin
                            if (w_full) begin
                                w_status = cdq_pkg::ST_FULL;
                            end else begin
                                w_cmd   = cdq_pkg::C_INS_FRONT;
                                n_count = r_count + 1'b1;
                            end
                        end
                        cdq_pkg::K_INS_BACK: begin
                            if (w_full) begin
                                w_status = cdq_pkg::ST_FULL;
                            end else begin
                                w_cmd   = cdq_pkg::C_INS_BACK;
                                n_count = r_count + 1'b1;
                            end
                        end
                        cdq_pkg::K_DEL_FRONT: begin
                            if (w_empty) begin
                                w_status = cdq_pkg::ST_EMPTY;
                            end else begin
                                w_cmd   = cdq_pkg::C_DEL_FRONT;
                                n_count = r_count - 1'b1;
                            end
                        end
                        cdq_pkg::K_DEL_BACK: begin
                            if (w_empty) begin
                                w_status = cdq_pkg::ST_EMPTY;
                            end else begin
                                w_cmd   = cdq_pkg::C_DEL_BACK;
                                n_count = r_count - 1'b1;
                            end
                        end
                        cdq_pkg::K_DEL_VALUE: begin
                            if (w_empty) begin
                                w_status = cdq_pkg::ST_EMPTY;
                            end else begin
                                // hold the result until the search ends
                                w_load = 1'b0;
                                n_key  = w_in_value;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            cdq_pkg::S_SEED: begin
                // drop the token into the front cell
                w_cmd  = cdq_pkg::C_SCAN;
                w_seed = 1'b1;
            end
            cdq_pkg::S_SCAN: begin
                if (w_hit) begin
                    if (w_out_free) begin
                        w_cmd   = cdq_pkg::C_REMOVE;
                        w_load  = 1'b1;
                        n_count = r_count - 1'b1;
                    end
                end else if (w_miss) begin
                    if (w_out_free) begin
                        w_cmd    = cdq_pkg::C_ABORT;
                        w_load   = 1'b1;
                        w_status = cdq_pkg::ST_NOT_FOUND;
                    end
                end else begin
                    // advance the token one cell
                    w_cmd = cdq_pkg::C_SCAN;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cdq_pkg::S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        if (w_load) begin
            r_out_item.status      <= w_status;
            r_out_item.entry_count <= cdq_pkg::ENTRY_COUNT_BITS'(n_count);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Count tracks the occupied cells whenever the chain is at rest.
    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cdq_pkg::S_IDLE) |-> (r_count == $countones(w_valid_map)))
        else $error("node count differs from occupied cells");

    // Occupied cells always form an unbroken run from the front.
    a_packed_front: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid_map & (w_valid_map + 1'b1)) == '0)
        else $error("gap in the cell chain");

    // At most one search token travels the chain.
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_tok_map))
        else $error("more than one search token");

    // No token is left behind once a search is over.
    a_token_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != cdq_pkg::S_SCAN) |-> (w_tok_map == '0))
        else $error("search token outside a search");

    // A search that reports not found leaves the count alone.
    a_miss_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && (w_status == cdq_pkg::ST_NOT_FOUND)) |=> $stable(r_count))
        else $error("count changed on a failed search");

endmodule
